@@ hdl/ceos_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceos_pkg
// Shared sizes for the concave envelope outlier scan unit.
// ----------------------------------------------------------------------------
package ceos_pkg;

  // score storage and index sizes
  localparam int MAX_MODELS = 32;
  localparam int SCORE_W    = 48;
  localparam int IDX_W      = $clog2(MAX_MODELS);
  localparam int CNT_W      = $clog2(MAX_MODELS + 1);
  localparam int SCAN_W     = IDX_W + 1;

  // slope cross-multiplication sizes
  localparam int DIFF_W     = SCORE_W + 1;
  localparam int PROD_W     = DIFF_W + IDX_W + 1;

  // stream payload sizes
  localparam int IN_TDATA_W  = ((SCORE_W + 7) / 8) * 8;
  localparam int OUT_IDX_W   = 5;
  localparam int OUT_TDATA_W = ((OUT_IDX_W + 7) / 8) * 8;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

endpackage

@@ hdl/concave_envelope_outlier_scan_unit.sv @@
`timescale 1ns / 1ps
// Scores load one per cycle while the unit is idle; the marked score starts the envelope walk.
// Walk: each envelope point loads its base and first candidate, then each further
// candidate is read, differenced, multiplied and compared, and each index is emitted.
// Throughput is set by the single read port of the score memory and the
// diff/multiply/compare sequence; no score is taken while a walk runs.
// Reset (rst_n low, synchronous) clears the run count, sequencer and output.
// ----------------------------------------------------------------------------
// concave_envelope_outlier_scan_unit
// Stores a run of Q32.16 scores and emits the indices that lie strictly under
// the upper concave envelope, then the final index with tlast.
// ----------------------------------------------------------------------------
module concave_envelope_outlier_scan_unit
  import ceos_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [47:0] score
  input  logic                   in_tlast,   // last_model
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [4:0] model_index, rest zero
  output logic                   out_tlast   // last
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_LBASE = 4'd2;
  localparam logic [3:0] ST_LBEST = 4'd3;
  localparam logic [3:0] ST_READ  = 4'd4;
  localparam logic [3:0] ST_DIFF  = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;
  localparam logic [3:0] ST_FINAL = 4'd9;

  // control registers
  logic [3:0]       state_r,    state_nxt;
  logic [CNT_W-1:0] count_r,    count_nxt;
  logic [IDX_W-1:0] final_r,    final_nxt;
  logic [IDX_W-1:0] cpt_r,      cpt_nxt;
  logic [IDX_W-1:0] best_r,     best_nxt;
  logic [SCAN_W-1:0] scan_r,    scan_nxt;
  logic             out_vld_r,  out_vld_nxt;

  // payload registers
  score_t                 base_r,       base_nxt;
  score_t                 best_score_r, best_score_nxt;
  score_t                 scan_score_r, scan_score_nxt;
  diff_t                  diff_scan_r,  diff_scan_nxt;
  diff_t                  diff_best_r,  diff_best_nxt;
  prod_t                  lhs_r,        lhs_nxt;
  prod_t                  rhs_r,        rhs_nxt;
  logic [OUT_IDX_W-1:0]   out_idx_r,    out_idx_nxt;
  logic                   out_last_r,   out_last_nxt;

  // memory port signals
  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [SCORE_W-1:0] ram_rdata;
  score_t             rd_score;

  logic               in_acc;
  logic               out_free;
  logic               room;
  logic [IDX_W-1:0]   run_best;
  logic [IDX_W-1:0]   run_scan;
  logic [SCAN_W-1:0]  scan_inc;
  logic [SCAN_W-1:0]  final_ext;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  assign room      = (count_r < CNT_W'(MAX_MODELS));
  assign ram_we    = in_acc && room;
  assign rd_score  = score_t'(ram_rdata);
  assign run_best  = best_r - cpt_r;
  assign run_scan  = scan_r[IDX_W-1:0] - cpt_r;
  assign scan_inc  = scan_r + SCAN_W'(1);
  assign final_ext = {1'b0, final_r};

  // score store
  ceos_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_MODELS)
  ) u_score_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (in_tdata[SCORE_W-1:0]),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // read address select
  always_comb begin
    unique case (state_r)
      ST_START: ram_raddr = cpt_r;
      ST_LBASE: ram_raddr = cpt_r + IDX_W'(1);
      default:  ram_raddr = scan_r[IDX_W-1:0];
    endcase
  end

  // walk sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    final_nxt      = final_r;
    cpt_nxt        = cpt_r;
    best_nxt       = best_r;
    scan_nxt       = scan_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    base_nxt       = base_r;
    best_score_nxt = best_score_r;
    scan_score_nxt = scan_score_r;
    diff_scan_nxt  = diff_scan_r;
    diff_best_nxt  = diff_best_r;
    lhs_nxt        = lhs_r;
    rhs_nxt        = rhs_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (room) begin
            count_nxt = count_r + CNT_W'(1);
            final_nxt = count_r[IDX_W-1:0];
          end else begin
            final_nxt = IDX_W'(MAX_MODELS - 1);
          end
          if (in_tlast) begin
            cpt_nxt = '0;
            if ((room && count_r == '0) || (!room && MAX_MODELS == 1)) begin
              state_nxt = ST_FINAL;
            end else begin
              state_nxt = ST_START;
            end
          end
        end
      end
      ST_START: begin
        state_nxt = ST_LBASE;
      end
      ST_LBASE: begin
        base_nxt  = rd_score;
        state_nxt = ST_LBEST;
      end
      ST_LBEST: begin
        best_score_nxt = rd_score;
        best_nxt       = cpt_r + IDX_W'(1);
        if ({1'b0, cpt_r} + SCAN_W'(2) > final_ext) begin
          scan_nxt  = {1'b0, cpt_r} + SCAN_W'(1);
          state_nxt = ST_EMIT;
        end else begin
          scan_nxt  = {1'b0, cpt_r} + SCAN_W'(2);
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        scan_score_nxt = rd_score;
        diff_scan_nxt  = DIFF_W'(rd_score) - DIFF_W'(base_r);
        diff_best_nxt  = DIFF_W'(best_score_r) - DIFF_W'(base_r);
        state_nxt      = ST_MUL;
      end
      ST_MUL: begin
        lhs_nxt   = prod_t'(diff_scan_r) * prod_t'($signed({1'b0, run_best}));
        rhs_nxt   = prod_t'(diff_best_r) * prod_t'($signed({1'b0, run_scan}));
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (lhs_r > rhs_r) begin
          best_nxt       = scan_r[IDX_W-1:0];
          best_score_nxt = scan_score_r;
        end
        if (scan_inc > final_ext) begin
          scan_nxt  = {1'b0, cpt_r} + SCAN_W'(1);
          state_nxt = ST_EMIT;
        end else begin
          scan_nxt  = scan_inc;
          state_nxt = ST_READ;
        end
      end
      ST_EMIT: begin
        if (scan_r < {1'b0, best_r}) begin
          if (out_free) begin
            out_vld_nxt  = 1'b1;
            out_idx_nxt  = OUT_IDX_W'(scan_r);
            out_last_nxt = 1'b0;
            scan_nxt     = scan_inc;
          end
        end else begin
          cpt_nxt = best_r;
          if (best_r == final_r) begin
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_START;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_idx_nxt  = OUT_IDX_W'(final_r);
          out_last_nxt = 1'b1;
          count_nxt    = '0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      final_r   <= '0;
      cpt_r     <= '0;
      best_r    <= '0;
      scan_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      final_r   <= final_nxt;
      cpt_r     <= cpt_nxt;
      best_r    <= best_nxt;
      scan_r    <= scan_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // datapath and output payload
  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    best_score_r <= best_score_nxt;
    scan_score_r <= scan_score_nxt;
    diff_scan_r  <= diff_scan_nxt;
    diff_best_r  <= diff_best_nxt;
    lhs_r        <= lhs_nxt;
    rhs_r        <= rhs_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(out_idx_r);
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // the best candidate always lies past the current envelope point
  a_best_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_DIFF || state_r == ST_MUL ||
     state_r == ST_CMP || state_r == ST_EMIT) |-> (best_r > cpt_r))
    else $error("best point not ahead of envelope point");

  // candidates under test never pass the final index
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_DIFF || state_r == ST_MUL ||
     state_r == ST_CMP) |-> (scan_r <= final_ext))
    else $error("candidate beyond final index");

  // issuing the final index clears the run count and raises out_tlast
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINAL && out_free) |=> (count_r == '0 && out_tlast))
    else $error("final request without run count clear");

  // inner indices stay below the final index
  a_inner_below: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_last_r) |-> (out_idx_r < OUT_IDX_W'(final_r)))
    else $error("inner index not below final index");
`endif

endmodule

@@ hdl/ceos_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceos_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ceos_ram #(
  parameter int  WIDTH = 48,
  parameter int  DEPTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the concave envelope outlier scan unit: runs of
// scores go in through a stalling stream, an in-bench envelope walk predicts
// the emitted indices, and every result is compared in order.
// ----------------------------------------------------------------------------
module testbench
  import ceos_pkg::*;
();

  // one score request as the driver presents it
  typedef struct {
    score_t score;
    logic   mark;
    int     gap;
    bit     drain;
  } score_req_t;

  // one emitted index as the monitor expects it
  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic                 last;
  } outlier_t;

  localparam score_t SCORE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam score_t SCORE_MIN = 48'sh8000_0000_0000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [47:0] score
  logic                   in_tlast   = 1'b0; // last_model
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [4:0] model_index, rest zero
  logic                   out_tlast;         // last

  score_req_t score_queue[$];
  outlier_t   outlier_queue[$];
  score_req_t next_req;
  outlier_t   got_res;
  outlier_t   exp_res;

  // predictor copy of the score run
  score_t      held_scores [MAX_MODELS];
  int unsigned held_count = 0;

  int err_cnt        = 0;
  int total_items    = 0;
  int accepted_items = 0;
  int results_seen   = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int calm_left      = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  concave_envelope_outlier_scan_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // score content: full range, a narrow band for ties, extremes, or sign-extended 32-bit values
  function automatic score_t pick_score(int mode);
    logic [63:0] w;
    int          r;
    w = {$urandom, $urandom};
    case (mode)
      0: return score_t'(w[SCORE_W-1:0]);
      1: return score_t'($urandom_range(0, 8)) - score_t'(4);
      2: begin
        r = $urandom_range(0, 4);
        case (r)
          0: return SCORE_MAX;
          1: return SCORE_MIN;
          2: return score_t'(0);
          3: return score_t'(-1);
          default: return score_t'(1);
        endcase
      end
      default: return score_t'({{16{w[31]}}, w[31:0]});
    endcase
  endfunction

  task automatic add_score(score_t s, logic mark, int gap, bit drain);
    score_req_t q;
    q.score = s;
    q.mark  = mark;
    q.gap   = gap;
    q.drain = drain;
    score_queue = {score_queue, q};
    total_items++;
  endtask

  // envelope walk on the held run, emitting indices under the envelope
  task automatic envelope_accept(score_t s, logic mark);
    int       fin;
    int       c;
    int       best;
    int       k;
    longint   base;
    longint   lhs;
    longint   rhs;
    outlier_t o;
    if (held_count < MAX_MODELS) begin
      held_scores[held_count] = s;
      held_count++;
    end
    if (mark) begin
      fin = held_count - 1;
      c   = 0;
      while (c < fin) begin
        base = longint'(held_scores[c]);
        best = c + 1;
        for (k = c + 2; k <= fin; k++) begin
          lhs = (longint'(held_scores[k]) - base) * longint'(best - c);
          rhs = (longint'(held_scores[best]) - base) * longint'(k - c);
          if (lhs > rhs) best = k;
        end
        for (k = c + 1; k < best; k++) begin
          o.idx  = k[OUT_IDX_W-1:0];
          o.last = 1'b0;
          outlier_queue = {outlier_queue, o};
        end
        c = best;
      end
      o.idx  = fin[OUT_IDX_W-1:0];
      o.last = 1'b1;
      outlier_queue = {outlier_queue, o};
      held_count = 0;
    end
  endtask

  // driver: presents queued score requests, holds them until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        envelope_accept(score_t'(in_tdata[SCORE_W-1:0]), in_tlast);
        accepted_items++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (score_queue.size() > 0 &&
                     !(score_queue[0].drain && outlier_queue.size() > 0)) begin
          next_req = score_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'(next_req.score);
          in_tlast  <= next_req.mark;
          gap_left  = (score_queue.size() > 0) ? score_queue[0].gap : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken result and paces out_tready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_res.idx  = out_tdata[OUT_IDX_W-1:0];
        got_res.last = out_tlast;
        results_seen++;
        if (outlier_queue.size() == 0) begin
          $error("unexpected result: model_index %0d last %0b", got_res.idx, got_res.last);
          err_cnt++;
        end else begin
          exp_res = outlier_queue.pop_front();
          if (got_res.idx !== exp_res.idx) begin
            $error("model_index: expected %0d, actual %0d", exp_res.idx, got_res.idx);
            err_cnt++;
          end
          if (got_res.last !== exp_res.last) begin
            $error("last: expected %0b, actual %0b", exp_res.last, got_res.last);
            err_cnt++;
          end
        end
        // one long hold-off so the unit backs up into its input
        if (!hold_done && results_seen == 6) begin
          hold_left = 400;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        else if ($urandom_range(0, 199) == 0) calm_left = 60;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int  run_len;
    int  mode;
    int  n;
    int  k;
    bit  calm;
    bit  long_done;
    bit  drain;

    // directed: single scores at the extremes
    add_score(SCORE_MAX, 1'b1, 0, 1'b0);
    add_score(SCORE_MIN, 1'b1, 2, 1'b0);
    // two scores, full swing
    add_score(SCORE_MIN, 1'b0, 0, 1'b0);
    add_score(SCORE_MAX, 1'b1, 0, 1'b0);
    // deep dip between two maxima
    add_score(SCORE_MAX, 1'b0, 0, 1'b0);
    add_score(SCORE_MIN, 1'b0, 1, 1'b0);
    add_score(SCORE_MAX, 1'b1, 0, 1'b0);
    // flat run, every slope ties
    for (k = 0; k < 4; k++) add_score(score_t'(5), k == 3, 0, 1'b0);
    // collinear tie, earliest wins
    add_score(score_t'(0), 1'b0, 0, 1'b1);
    add_score(score_t'(10), 1'b0, 0, 1'b0);
    add_score(score_t'(20), 1'b1, 0, 1'b0);
    // two points under a rising chord
    add_score(score_t'(0), 1'b0, 0, 1'b0);
    add_score(score_t'(-5), 1'b0, 0, 1'b0);
    add_score(score_t'(10), 1'b0, 0, 1'b0);
    add_score(score_t'(20), 1'b1, 0, 1'b0);
    // alternating bit patterns
    add_score(48'sh5555_5555_5555, 1'b0, 0, 1'b0);
    add_score(48'shAAAA_AAAA_AAAA, 1'b0, 0, 1'b0);
    add_score(48'sh5555_5555_5555, 1'b1, 0, 1'b0);

    // random runs; the first is long enough to overflow the store
    long_done = 1'b0;
    n = 0;
    while (n < 86) begin
      if (!long_done) begin
        run_len   = 34;
        long_done = 1'b1;
      end else if (n > 60 && $urandom_range(0, 19) == 0) begin
        run_len = $urandom_range(31, 35);
      end else begin
        run_len = $urandom_range(1, 8);
      end
      mode  = $urandom_range(0, 3);
      calm  = ($urandom_range(0, 4) == 0);
      drain = ($urandom_range(0, 9) == 0);
      for (k = 0; k < run_len; k++) begin
        add_score(pick_score(mode), k == run_len - 1, calm ? 0 : pick_gap(),
                  (k == 0) && drain);
      end
      n += run_len;
    end
    // final run starts only once everything before it has drained
    add_score(pick_score(0), 1'b0, 3, 1'b1);
    add_score(pick_score(0), 1'b0, 0, 1'b0);
    add_score(pick_score(0), 1'b1, 0, 1'b0);

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items < total_items) @(posedge clk);
    while (outlier_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
